/* design/wkb_pkg.sv */
// ----------------------------------------------------------------------------
// wkb_pkg: shared constants, types and codes for the WKB transmission block
// Fixed-point formats, serial-unit widths and the state encodings.
// ----------------------------------------------------------------------------
package wkb_pkg;

  // Fixed-point format of potential and energy (Q16.16).
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int DIFF_W    = DATA_W + 1;
  localparam int SUM_W     = 44;
  localparam int T_W       = 17;

  // Square root operand: the difference shifted left by FRAC_BITS + 1,
  // padded to an even width so that it splits into bit pairs.
  localparam int RAD_BITS   = DATA_W + FRAC_BITS + 1;
  localparam int RAD_W      = RAD_BITS + (RAD_BITS % 2);
  localparam int ROOT_W     = RAD_W / 2;
  localparam int ROOT_CNT_W = $clog2(ROOT_W);

  // Sample counter saturates at two.
  localparam int               COUNT_W   = 2;
  localparam logic [COUNT_W-1:0] COUNT_SAT = COUNT_W'(2);

  // The exponential is flushed to zero once 2*sum reaches 12.0.
  localparam logic [SUM_W-1:0] FLUSH_LIMIT = SUM_W'(64'd6 << FRAC_BITS);
  localparam int XS_W    = FRAC_BITS + 3;
  localparam int Y_SHIFT = 27 - FRAC_BITS;
  localparam int Y_W     = XS_W + Y_SHIFT;

  // Q30 arithmetic of the exponential unit, with one integer bit.
  localparam int               Q_W       = 31;
  localparam logic [Q_W-1:0]   Q30_ONE   = {1'b1, {(Q_W-1){1'b0}}};
  localparam int               ACC_W     = Q_W + 2;
  localparam int               BIT_CNT_W = $clog2(Q_W);
  localparam int               SERIES_TERMS = 20;
  localparam int               K_W       = $clog2(SERIES_TERMS + 1);
  localparam int               SQUARINGS = 4;
  localparam int               SQ_W      = $clog2(SQUARINGS);
  localparam int               OUT_SHIFT = 14;
  localparam logic [T_W-1:0]   T_ONE     = T_W'(65536);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROOT,
    ST_FIN,
    ST_EXP,
    ST_EMIT
  } top_state_t;

  typedef enum logic [2:0] {
    EX_IDLE,
    EX_MUL,
    EX_DIV,
    EX_ACC,
    EX_SQR,
    EX_DONE
  } exp_state_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] diff;
  } root_req_t;

  typedef struct packed {
    logic           done;
    logic [T_W-1:0] result;
  } exp_stat_t;

endpackage

/* design/wkb_isqrt.sv */
// ----------------------------------------------------------------------------
// wkb_isqrt: bit-serial integer square root
// Restoring digit recurrence, one root bit per cycle over bit pairs of the
// difference shifted left by FRAC_BITS + 1.
// ----------------------------------------------------------------------------
module wkb_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  wkb_pkg::root_req_t          req,
  output logic                        done,
  output logic [wkb_pkg::ROOT_W-1:0]  root
);

  logic                               busy;
  logic [wkb_pkg::RAD_W-1:0]          rad;
  logic [wkb_pkg::ROOT_W:0]           rem;
  logic [wkb_pkg::ROOT_W-1:0]         root_r;
  logic [wkb_pkg::ROOT_CNT_W-1:0]     cnt;
  logic [wkb_pkg::ROOT_W+2:0]         r2;
  logic [wkb_pkg::ROOT_W+2:0]         trial;
  logic                               ge;
  logic                               last_step;

  assign r2        = {rem, rad[wkb_pkg::RAD_W-1 -: 2]};
  assign trial     = {1'b0, root_r, 2'b01};
  assign ge        = (r2 >= trial);
  assign last_step = (cnt == wkb_pkg::ROOT_CNT_W'(wkb_pkg::ROOT_W - 1));
  assign root      = root_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && last_step;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last_step) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rad    <= wkb_pkg::RAD_W'({req.diff, {(wkb_pkg::FRAC_BITS + 1){1'b0}}});
      rem    <= '0;
      root_r <= '0;
    end else if (busy) begin
      rad <= rad << 2;
      // The remainder never exceeds twice the partial root, so it fits.
      if (ge) begin
        rem <= (wkb_pkg::ROOT_W + 1)'(r2 - trial);
      end else begin
        rem <= (wkb_pkg::ROOT_W + 1)'(r2);
      end
      root_r <= {root_r[wkb_pkg::ROOT_W-2:0], ge};
    end
  end

endmodule

/* design/wkb_exp.sv */
// ----------------------------------------------------------------------------
// wkb_exp: serial exp(-2*sum) unit
// Taylor series of exp(-x/16) in Q30 with a shift-add multiplier and a
// restoring divider, then four rounded squarings and rounding to Q1.16.
// ----------------------------------------------------------------------------
module wkb_exp (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [wkb_pkg::XS_W-1:0]   sum_in,
  output wkb_pkg::exp_stat_t         stat
);

  wkb_pkg::exp_state_t               state;
  wkb_pkg::exp_state_t               state_next;

  logic [wkb_pkg::Y_W-1:0]           y;
  logic signed [wkb_pkg::ACC_W-1:0]  acc;
  logic [wkb_pkg::K_W-1:0]           k;
  logic [wkb_pkg::SQ_W-1:0]          sq;
  logic [wkb_pkg::Q_W-1:0]           mcand;
  logic [wkb_pkg::Q_W-1:0]           hi;
  logic [wkb_pkg::Q_W-1:0]           lo;
  logic [wkb_pkg::Q_W-1:0]           num;
  logic [wkb_pkg::K_W-1:0]           rem;
  logic [wkb_pkg::BIT_CNT_W-1:0]     cnt;
  logic [wkb_pkg::Q_W-1:0]           e;
  logic                              done_r;
  logic [wkb_pkg::T_W-1:0]           result_r;

  logic [wkb_pkg::Q_W:0]             psum;
  logic [wkb_pkg::K_W:0]             r2;
  logic                              dge;
  logic                              cnt_last;
  logic                              k_last;
  logic                              sq_last;
  logic signed [wkb_pkg::ACC_W-1:0]  acc_new;
  logic [wkb_pkg::Q_W-1:0]           acc_clamp;
  logic [wkb_pkg::Q_W-1:0]           e_sq;
  logic [wkb_pkg::Q_W:0]             e_rnd;
  logic [wkb_pkg::T_W-1:0]           t_round;

  // One shift-add step; after the last step psum equals the product >> 30.
  assign psum = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : '0);
  assign r2   = {rem, num[wkb_pkg::Q_W-1]};
  assign dge  = (r2 >= {1'b0, k});

  assign cnt_last = (cnt == wkb_pkg::BIT_CNT_W'(wkb_pkg::Q_W - 1));
  assign k_last   = (k == wkb_pkg::K_W'(wkb_pkg::SERIES_TERMS));
  assign sq_last  = (sq == wkb_pkg::SQ_W'(wkb_pkg::SQUARINGS - 1));

  // Odd terms of the series are subtracted.
  assign acc_new = k[0] ? acc - $signed({2'b00, num}) : acc + $signed({2'b00, num});

  always_comb begin
    if (acc_new < 0) begin
      acc_clamp = '0;
    end else if (acc_new > $signed({2'b00, wkb_pkg::Q30_ONE})) begin
      acc_clamp = wkb_pkg::Q30_ONE;
    end else begin
      acc_clamp = acc_new[wkb_pkg::Q_W-1:0];
    end
  end

  // The bit below the Q30 point of the square is the half-up rounding bit.
  assign e_sq = wkb_pkg::Q_W'(psum) + wkb_pkg::Q_W'(lo[wkb_pkg::Q_W-1]);

  assign e_rnd = {1'b0, e} + (wkb_pkg::Q_W + 1)'(1 << (wkb_pkg::OUT_SHIFT - 1));

  always_comb begin
    if (e_rnd[wkb_pkg::Q_W:wkb_pkg::OUT_SHIFT] >
        (wkb_pkg::Q_W + 1 - wkb_pkg::OUT_SHIFT)'(wkb_pkg::T_ONE)) begin
      t_round = wkb_pkg::T_ONE;
    end else begin
      t_round = wkb_pkg::T_W'(e_rnd[wkb_pkg::Q_W:wkb_pkg::OUT_SHIFT]);
    end
  end

  assign stat.done   = done_r;
  assign stat.result = result_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wkb_pkg::EX_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      wkb_pkg::EX_IDLE: begin
        if (start) begin
          state_next = wkb_pkg::EX_MUL;
        end
      end
      wkb_pkg::EX_MUL: begin
        if (cnt_last) begin
          state_next = wkb_pkg::EX_DIV;
        end
      end
      wkb_pkg::EX_DIV: begin
        if (cnt_last) begin
          state_next = wkb_pkg::EX_ACC;
        end
      end
      wkb_pkg::EX_ACC: begin
        state_next = k_last ? wkb_pkg::EX_SQR : wkb_pkg::EX_MUL;
      end
      wkb_pkg::EX_SQR: begin
        if (cnt_last && sq_last) begin
          state_next = wkb_pkg::EX_DONE;
        end
      end
      wkb_pkg::EX_DONE: begin
        state_next = wkb_pkg::EX_IDLE;
      end
      default: begin
        state_next = wkb_pkg::EX_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done_r <= 1'b0;
    end else begin
      done_r <= (state == wkb_pkg::EX_DONE);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      wkb_pkg::EX_IDLE: begin
        if (start) begin
          y     <= {sum_in, {wkb_pkg::Y_SHIFT{1'b0}}};
          acc   <= $signed({2'b00, wkb_pkg::Q30_ONE});
          k     <= wkb_pkg::K_W'(1);
          mcand <= wkb_pkg::Q30_ONE;
          lo    <= wkb_pkg::Q_W'({sum_in, {wkb_pkg::Y_SHIFT{1'b0}}});
          hi    <= '0;
          cnt   <= '0;
        end
      end
      wkb_pkg::EX_MUL: begin
        hi  <= psum[wkb_pkg::Q_W:1];
        lo  <= {psum[0], lo[wkb_pkg::Q_W-1:1]};
        if (cnt_last) begin
          num <= wkb_pkg::Q_W'(psum);
          rem <= '0;
          cnt <= '0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      wkb_pkg::EX_DIV: begin
        if (dge) begin
          rem <= wkb_pkg::K_W'(r2 - {1'b0, k});
        end else begin
          rem <= wkb_pkg::K_W'(r2);
        end
        num <= {num[wkb_pkg::Q_W-2:0], dge};
        cnt <= cnt + 1'b1;
      end
      wkb_pkg::EX_ACC: begin
        acc <= acc_new;
        hi  <= '0;
        cnt <= '0;
        if (k_last) begin
          mcand <= acc_clamp;
          lo    <= acc_clamp;
          sq    <= '0;
        end else begin
          k     <= k + 1'b1;
          mcand <= num;
          lo    <= wkb_pkg::Q_W'(y);
        end
      end
      wkb_pkg::EX_SQR: begin
        if (cnt_last) begin
          e     <= e_sq;
          mcand <= e_sq;
          lo    <= e_sq;
          hi    <= '0;
          cnt   <= '0;
          sq    <= sq + 1'b1;
        end else begin
          hi  <= psum[wkb_pkg::Q_W:1];
          lo  <= {psum[0], lo[wkb_pkg::Q_W-1:1]};
          cnt <= cnt + 1'b1;
        end
      end
      wkb_pkg::EX_DONE: begin
        result_r <= t_round;
      end
      default: begin
      end
    endcase
  end

endmodule

/* design/wkb_barrier_transmission.sv */
// ----------------------------------------------------------------------------
// wkb_barrier_transmission: WKB tunneling transmission of a sampled barrier
// Accumulates sqrt(2*(V-E)) over the samples of a barrier and returns
// exp(-2*sum) in unsigned Q1.16 on the final sample.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake               | Payload
//  ---------+-------------------------+------------------------------------
//  in       | in_valid / in_ready     | potential (Q16.16 signed), last
//  out      | out_valid / out_ready   | transmission (Q1.16), too_short
//  cfg      | cfg_valid / cfg_ready   | energy_level (Q16.16 signed)
//
// A sample at or below the energy skips the square root; one above it waits
// for the bit-serial square root (one root bit per cycle, 25 bits).
// A final sample also runs the serial exponential (20 series terms of a
// multiply and a divide, then four squarings), unless the result is known
// to be zero.
// Reset is synchronous and clears the energy, the action sum and the count.
// A waiting result does not stall non-final samples; a final sample waits
// for the output register to drain.
// ----------------------------------------------------------------------------
module wkb_barrier_transmission (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [wkb_pkg::DATA_W-1:0]     potential,
  input  logic                           last,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [wkb_pkg::T_W-1:0]        transmission,
  output logic                           too_short,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [wkb_pkg::DATA_W-1:0]     energy_level
);

  wkb_pkg::top_state_t               state;
  wkb_pkg::top_state_t               state_next;

  logic [wkb_pkg::DATA_W-1:0]        energy;
  logic [wkb_pkg::SUM_W-1:0]         sum;
  logic [wkb_pkg::COUNT_W-1:0]       count;
  logic                              last_r;
  logic [wkb_pkg::T_W-1:0]           pend_t;
  logic                              pend_short;

  logic [wkb_pkg::DIFF_W-1:0]        diff;
  logic                              pos;
  logic                              accept;
  logic [wkb_pkg::SUM_W:0]           sum_add;
  logic [wkb_pkg::SUM_W-1:0]         sum_sat;
  logic                              exp_start;
  logic                              out_free;

  wkb_pkg::root_req_t                root_req;
  logic                              root_done;
  logic [wkb_pkg::ROOT_W-1:0]        root;
  wkb_pkg::exp_stat_t                exp_stat;

  assign diff = {potential[wkb_pkg::DATA_W-1], potential}
              - {energy[wkb_pkg::DATA_W-1], energy};
  assign pos  = !diff[wkb_pkg::DIFF_W-1] && (|diff[wkb_pkg::DATA_W-1:0]);

  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  assign root_req.start = accept && pos;
  assign root_req.diff  = diff[wkb_pkg::DATA_W-1:0];

  assign sum_add = {1'b0, sum} + (wkb_pkg::SUM_W + 1)'(root);
  assign sum_sat = sum_add[wkb_pkg::SUM_W] ? '1 : sum_add[wkb_pkg::SUM_W-1:0];

  wkb_isqrt u_isqrt (
    .clk  (clk),
    .rst  (rst),
    .req  (root_req),
    .done (root_done),
    .root (root)
  );

  wkb_exp u_exp (
    .clk    (clk),
    .rst    (rst),
    .start  (exp_start),
    .sum_in (sum[wkb_pkg::XS_W-1:0]),
    .stat   (exp_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wkb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    exp_start  = 1'b0;
    case (state)
      wkb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = pos ? wkb_pkg::ST_ROOT : wkb_pkg::ST_FIN;
        end
      end
      wkb_pkg::ST_ROOT: begin
        if (root_done) begin
          state_next = wkb_pkg::ST_FIN;
        end
      end
      wkb_pkg::ST_FIN: begin
        if (!last_r) begin
          state_next = wkb_pkg::ST_IDLE;
        end else if (count != wkb_pkg::COUNT_SAT || sum >= wkb_pkg::FLUSH_LIMIT) begin
          state_next = wkb_pkg::ST_EMIT;
        end else begin
          exp_start  = 1'b1;
          state_next = wkb_pkg::ST_EXP;
        end
      end
      wkb_pkg::ST_EXP: begin
        if (exp_stat.done) begin
          state_next = wkb_pkg::ST_EMIT;
        end
      end
      wkb_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = wkb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = wkb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      energy    <= '0;
      sum       <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        energy <= energy_level;
      end
      if (accept && count != wkb_pkg::COUNT_SAT) begin
        count <= count + 1'b1;
      end
      if (state == wkb_pkg::ST_ROOT && root_done) begin
        sum <= sum_sat;
      end
      // The barrier ends here; a started exponential latches the old sum.
      if (state == wkb_pkg::ST_FIN && last_r) begin
        sum   <= '0;
        count <= '0;
      end
      if (state == wkb_pkg::ST_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_r <= last;
    end
    if (state == wkb_pkg::ST_FIN && last_r) begin
      pend_t     <= '0;
      pend_short <= (count != wkb_pkg::COUNT_SAT);
    end
    if (state == wkb_pkg::ST_EXP && exp_stat.done) begin
      pend_t     <= exp_stat.result;
      pend_short <= 1'b0;
    end
    if (state == wkb_pkg::ST_EMIT && out_free) begin
      transmission <= pend_t;
      too_short    <= pend_short;
    end
  end

endmodule

/* design/wkb_chk.sv */
// ----------------------------------------------------------------------------
// wkb_chk: port-level checks for the WKB transmission block
// Watches the top-level ports and is attached to it by a bind statement.
// ----------------------------------------------------------------------------
module wkb_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [wkb_pkg::DATA_W-1:0]  potential,
  input logic                        last,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [wkb_pkg::T_W-1:0]     transmission,
  input logic                        too_short,
  input logic                        cfg_valid,
  input logic                        cfg_ready,
  input logic [wkb_pkg::DATA_W-1:0]  energy_level
);

  // A short barrier always reports zero transmission.
  a_short_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && too_short |-> transmission == '0)
    else $error("too_short result with nonzero transmission");

  // The coefficient never exceeds 1.0.
  a_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> transmission <= wkb_pkg::T_ONE)
    else $error("transmission above 1.0");

  // A stalled result holds.
  a_hold : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(transmission) && $stable(too_short))
    else $error("result changed while stalled");

  // After reset the block is empty and ready for a request.
  a_reset : assert property (@(posedge clk)
    $past(rst) |-> !out_valid && in_ready)
    else $error("block not idle after reset");

  // A result does not appear directly after its request is accepted.
  a_no_instant : assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared directly after a request");

endmodule

bind wkb_barrier_transmission wkb_chk u_wkb_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .potential    (potential),
  .last         (last),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .transmission (transmission),
  .too_short    (too_short),
  .cfg_valid    (cfg_valid),
  .cfg_ready    (cfg_ready),
  .energy_level (energy_level)
);
